>>> hdl/nrt_pkg.sv
// Shared types, codes and constants of the name registry table.
`timescale 1ns / 1ps

package nrt_pkg;

    localparam int NAME_BYTES = 32;
    localparam int NAME_W     = 8 * NAME_BYTES;
    localparam int WORD_W     = 64;
    localparam int HANDLE_W   = 16;
    localparam int TYPE_W     = 4;
    localparam int RIGHTS_W   = 16;
    localparam int LEN_W      = 6;
    localparam int STATUS_W   = 3;
    localparam int ATTR_W     = HANDLE_W + TYPE_W + RIGHTS_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] OP_REGISTER   = 2'd0;
    localparam logic [1:0] OP_UNREGISTER = 2'd1;
    localparam logic [1:0] OP_RESOLVE    = 2'd2;
    localparam logic [1:0] OP_OPEN       = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_PERM     = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_INVALID_HANDLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_TYPE    = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [1:0]          op;
        logic [NAME_W-1:0]   name;
        logic [HANDLE_W-1:0] handle;
        logic [TYPE_W-1:0]   otype;
        logic [RIGHTS_W-1:0] grant;
        logic [RIGHTS_W-1:0] need;
        logic                bad;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [TYPE_W-1:0]   otype;
        logic [RIGHTS_W-1:0] rights;
    } t_resp;

endpackage

>>> hdl/name_registry_table.sv
// Top level of the name registry table: ports, configuration and result register.
`timescale 1ns / 1ps

// The name registry table keeps up to TABLE_ENTRIES named objects, each with
// a 32-byte name, a 16-bit handle, a 4-bit type and a 16-bit rights mask.
// Every request word is one of register, unregister, resolve or open, and
// produces exactly one result word. Names and attributes live in two
// registered-read RAMs with one row per slot, while the slot valid bits
// sit in flip-flops that reset clears at once, so the table is empty right
// after reset and no clearing pass is needed. A request is served by a
// sequential scan that reads one slot per cycle and compares its full name,
// stopping at the first match; register also notes the lowest free slot on
// the way. The result of a request is passed to the output register once
// the scan ends and that register is free, sooner when the name matches an
// early slot, and without any scan for a register request that fails its
// operand checks. The next request can be accepted once the scan has handed
// its result to the output register. One request is in work at a time; a
// finished result waits in the output register, so the next request is
// accepted while it is still pending. The configuration registers are
// written through their own channel and must only be changed while no
// request is in work.

module name_registry_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_op,
    input  logic [nrt_pkg::WORD_W-1:0]          i_name_word0,
    input  logic [nrt_pkg::WORD_W-1:0]          i_name_word1,
    input  logic [nrt_pkg::WORD_W-1:0]          i_name_word2,
    input  logic [nrt_pkg::WORD_W-1:0]          i_name_word3,
    input  logic [nrt_pkg::LEN_W-1:0]           i_name_length,
    input  logic [nrt_pkg::HANDLE_W-1:0]        i_object_handle,
    input  logic [nrt_pkg::TYPE_W-1:0]          i_object_type,
    input  logic [nrt_pkg::RIGHTS_W-1:0]        i_grant_rights,
    input  logic [nrt_pkg::RIGHTS_W-1:0]        i_needed_rights,

    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [nrt_pkg::STATUS_W-1:0]        o_status,
    output logic [nrt_pkg::HANDLE_W-1:0]        o_found_handle,
    output logic [nrt_pkg::TYPE_W-1:0]          o_found_type,
    output logic [nrt_pkg::RIGHTS_W-1:0]        o_found_rights,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nrt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [nrt_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // Configuration registers.
    logic [nrt_pkg::HANDLE_W-1:0] r_invalid_handle;
    logic [nrt_pkg::TYPE_W-1:0]   r_unused_type;

    // Result register that decouples the scan from the output channel.
    logic           r_out_valid;
    nrt_pkg::t_resp r_out;

    logic [nrt_pkg::NAME_W-1:0] eff_name;
    logic                       len_zero;
    logic                       len_full;
    nrt_pkg::t_req              req;
    logic                       resp_valid;
    logic                       resp_ready;
    nrt_pkg::t_resp             resp;

    // The configuration channel is always able to take a word.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invalid_handle <= '1;
            r_unused_type    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                nrt_pkg::CFG_INVALID_HANDLE: r_invalid_handle <= i_cfg_data;
                nrt_pkg::CFG_UNUSED_TYPE:    r_unused_type <= i_cfg_data[nrt_pkg::TYPE_W-1:0];
                default: ;
            endcase
        end
    end

    // The name is reduced to its effective bytes before it enters the scan,
    // so every comparison is a plain 256-bit equality.
    nrt_name_fmt u_name_fmt (
        .i_word0   (i_name_word0),
        .i_word1   (i_name_word1),
        .i_word2   (i_name_word2),
        .i_word3   (i_name_word3),
        .i_length  (i_name_length),
        .o_name    (eff_name),
        .o_len_zero(len_zero),
        .o_len_full(len_full)
    );

    // The operand checks of register are settled at acceptance; the scan
    // only looks at the flag when the operation is register.
    always_comb begin
        req.op     = i_op;
        req.name   = eff_name;
        req.handle = i_object_handle;
        req.otype  = i_object_type;
        req.grant  = i_grant_rights;
        req.need   = i_needed_rights;
        req.bad    = (i_object_handle == r_invalid_handle) ||
                     (i_object_type == r_unused_type) ||
                     len_zero || len_full;
    end

    nrt_scan #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .o_req_ready (o_ready),
        .i_req       (req),
        .o_resp_valid(resp_valid),
        .i_resp_ready(resp_ready),
        .o_resp      (resp)
    );

    // A new result moves in when the register is empty or its word leaves
    // in the same cycle.
    assign resp_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (resp_ready) begin
            r_out_valid <= resp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (resp_ready && resp_valid) begin
            r_out <= resp;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_found_handle = r_out.handle;
    assign o_found_type   = r_out.otype;
    assign o_found_rights = r_out.rights;

endmodule

>>> hdl/nrt_ram.sv
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps

module nrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/nrt_name_fmt.sv
// Effective-name formatter: cuts the name at its length or first zero byte.
`timescale 1ns / 1ps

module nrt_name_fmt (
    input  logic [nrt_pkg::WORD_W-1:0] i_word0,
    input  logic [nrt_pkg::WORD_W-1:0] i_word1,
    input  logic [nrt_pkg::WORD_W-1:0] i_word2,
    input  logic [nrt_pkg::WORD_W-1:0] i_word3,
    input  logic [nrt_pkg::LEN_W-1:0]  i_length,
    output logic [nrt_pkg::NAME_W-1:0] o_name,
    output logic                       o_len_zero,
    output logic                       o_len_full
);

    logic [nrt_pkg::NAME_W-1:0]     raw;
    logic [nrt_pkg::NAME_BYTES-1:0] nz;
    logic [nrt_pkg::NAME_BYTES-1:0] keep;
    logic [nrt_pkg::LEN_W-1:0]      lim;

    assign raw = {i_word3, i_word2, i_word1, i_word0};
    assign lim = (i_length > nrt_pkg::LEN_W'(nrt_pkg::NAME_BYTES)) ?
                 nrt_pkg::LEN_W'(nrt_pkg::NAME_BYTES) : i_length;

    // A byte survives when it lies below the length limit and no zero byte
    // comes at or before it.
    for (genvar g = 0; g < nrt_pkg::NAME_BYTES; g++) begin : g_byte
        assign nz[g]          = (raw[8*g +: 8] != 8'd0);
        assign keep[g]        = (nrt_pkg::LEN_W'(g) < lim) && (&nz[g:0]);
        assign o_name[8*g +: 8] = keep[g] ? raw[8*g +: 8] : 8'd0;
    end

    assign o_len_zero = !keep[0];
    assign o_len_full = keep[nrt_pkg::NAME_BYTES-1];

endmodule

>>> hdl/nrt_scan.sv
// Scan sequencer: walks the slot memories, matches names and applies updates.
`timescale 1ns / 1ps

module nrt_scan #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  nrt_pkg::t_req  i_req,
    output logic           o_resp_valid,
    input  logic           i_resp_ready,
    output nrt_pkg::t_resp o_resp
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    nrt_pkg::t_state          r_state, n_state;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [CNT_W-1:0]         r_rd_cnt, n_rd_cnt;
    logic                     r_cmp_vld, n_cmp_vld;
    logic                     r_free_found, n_free_found;
    logic [IDX_W-1:0]         r_cmp_idx, n_cmp_idx;
    logic [IDX_W-1:0]         r_free_idx, n_free_idx;
    nrt_pkg::t_req            r_req, n_req;
    nrt_pkg::t_resp           r_resp, n_resp;

    logic                        rd_issue;
    logic [nrt_pkg::NAME_W-1:0]  name_rdata;
    logic [nrt_pkg::ATTR_W-1:0]  attr_rdata;
    logic [nrt_pkg::RIGHTS_W-1:0] hit_rights;
    logic                        cmp_hit;
    logic                        cmp_last;
    logic                        cur_free;
    logic                        free_any;
    logic [IDX_W-1:0]            free_idx;
    logic                        done;
    logic                        ins_we;

    nrt_ram #(
        .WIDTH(nrt_pkg::NAME_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_name_ram (
        .i_clk  (i_clk),
        .i_we   (ins_we),
        .i_waddr(free_idx),
        .i_wdata(r_req.name),
        .i_re   (rd_issue),
        .i_raddr(r_rd_cnt[IDX_W-1:0]),
        .o_rdata(name_rdata)
    );

    nrt_ram #(
        .WIDTH(nrt_pkg::ATTR_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_attr_ram (
        .i_clk  (i_clk),
        .i_we   (ins_we),
        .i_waddr(free_idx),
        .i_wdata({r_req.handle, r_req.otype, r_req.grant}),
        .i_re   (rd_issue),
        .i_raddr(r_rd_cnt[IDX_W-1:0]),
        .o_rdata(attr_rdata)
    );

    assign rd_issue   = (r_state == nrt_pkg::S_SCAN) &&
                        (r_rd_cnt < CNT_W'(TABLE_ENTRIES));
    assign cmp_hit    = r_cmp_vld && r_valid[r_cmp_idx] && (name_rdata == r_req.name);
    assign cmp_last   = r_cmp_vld && (r_cmp_idx == IDX_W'(TABLE_ENTRIES - 1));
    assign cur_free   = r_cmp_vld && !r_valid[r_cmp_idx];
    assign free_any   = r_free_found || cur_free;
    assign free_idx   = r_free_found ? r_free_idx : r_cmp_idx;
    assign done       = (r_state == nrt_pkg::S_SCAN) && (cmp_hit || cmp_last);
    assign hit_rights = attr_rdata[nrt_pkg::RIGHTS_W-1:0];
    assign ins_we     = done && !cmp_hit && free_any && (r_req.op == nrt_pkg::OP_REGISTER);

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_rd_cnt     = r_rd_cnt;
        n_cmp_vld    = r_cmp_vld;
        n_free_found = r_free_found;
        n_cmp_idx    = r_cmp_idx;
        n_free_idx   = r_free_idx;
        n_req        = r_req;
        n_resp       = r_resp;
        o_req_ready  = 1'b0;
        o_resp_valid = 1'b0;

        unique case (r_state)
            nrt_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_req = i_req;
                    if ((i_req.op == nrt_pkg::OP_REGISTER) && i_req.bad) begin
                        n_resp  = '{status: nrt_pkg::ST_INVALID, default: '0};
                        n_state = nrt_pkg::S_RESP;
                    end else begin
                        n_rd_cnt     = '0;
                        n_cmp_vld    = 1'b0;
                        n_free_found = 1'b0;
                        n_state      = nrt_pkg::S_SCAN;
                    end
                end
            end
            nrt_pkg::S_SCAN: begin
                n_cmp_vld = rd_issue;
                n_cmp_idx = r_rd_cnt[IDX_W-1:0];
                if (rd_issue) begin
                    n_rd_cnt = r_rd_cnt + CNT_W'(1);
                end
                if (cur_free && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_cmp_idx;
                end
                if (done) begin
                    n_state = nrt_pkg::S_RESP;
                    n_resp  = '{status: nrt_pkg::ST_OK, default: '0};
                    unique case (r_req.op) inside
                        nrt_pkg::OP_REGISTER: begin
                            if (cmp_hit) begin
                                n_resp.status = nrt_pkg::ST_DUP;
                            end else if (free_any) begin
                                n_valid[free_idx] = 1'b1;
                            end else begin
                                n_resp.status = nrt_pkg::ST_FULL;
                            end
                        end
                        nrt_pkg::OP_UNREGISTER: begin
                            if (cmp_hit) begin
                                n_valid[r_cmp_idx] = 1'b0;
                            end else begin
                                n_resp.status = nrt_pkg::ST_NOTFOUND;
                            end
                        end
                        nrt_pkg::OP_RESOLVE, nrt_pkg::OP_OPEN: begin
                            if (!cmp_hit) begin
                                n_resp.status = nrt_pkg::ST_NOTFOUND;
                            end else if ((r_req.op == nrt_pkg::OP_OPEN) &&
                                         ((hit_rights & r_req.need) != r_req.need)) begin
                                n_resp.status = nrt_pkg::ST_PERM;
                            end else begin
                                n_resp.handle = attr_rdata[nrt_pkg::ATTR_W-1 -: nrt_pkg::HANDLE_W];
                                n_resp.otype  = attr_rdata[nrt_pkg::RIGHTS_W +: nrt_pkg::TYPE_W];
                                n_resp.rights = hit_rights;
                            end
                        end
                        default: begin
                            n_resp.status = nrt_pkg::ST_NOTFOUND;
                        end
                    endcase
                end
            end
            nrt_pkg::S_RESP: begin
                o_resp_valid = 1'b1;
                if (i_resp_ready) begin
                    n_state = nrt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nrt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= nrt_pkg::S_IDLE;
            r_valid      <= '0;
            r_rd_cnt     <= '0;
            r_cmp_vld    <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_rd_cnt     <= n_rd_cnt;
            r_cmp_vld    <= n_cmp_vld;
            r_free_found <= n_free_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= n_cmp_idx;
        r_free_idx <= n_free_idx;
        r_req      <= n_req;
        r_resp     <= n_resp;
    end

    assign o_resp = r_resp;

endmodule
